@@ design/iirdf1_pkg.sv @@
`default_nettype none

package iirdf1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // up to seven Q4.30 products, plus headroom
  localparam int ACC_W     = 38;
  localparam int MAX_ORDER = 3;
  localparam int ORDER_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;
  localparam int FRAC_W    = 15;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_2 = 3'd7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic clr;    // zero the accumulator
    logic issue;  // operands valid this cycle
    logic sub;    // subtract this product
  } mac_ctl_t;

  localparam acc_t RND_HALF = 38'sd16384;

  // round half up to Q1.15, then saturate to 16 bits
  function automatic sample_t round_sat(acc_t acc);
    acc_t                          t;
    logic signed [ACC_W-FRAC_W-1:0] q;
    sample_t                       r;
    t = acc + RND_HALF;
    q = t[ACC_W-1:FRAC_W];
    if (q > 23'sd32767) begin
      r = 16'sh7fff;
    end else if (q < -23'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/iirdf1_mac.sv @@
`default_nettype none

module iirdf1_mac import iirdf1_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mac_ctl_t ctl,
  input  wire sample_t  smp,
  input  wire coef_t    coef,
  output acc_t          acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic                     prod_sub_r;
  acc_t                     acc_r;
  acc_t                     prod_ext;

  assign prod_ext = acc_t'(prod_r);

  // stage 1: registered product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      prod_sub_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.issue;
      prod_sub_r <= ctl.sub;
    end
    prod_r <= smp * coef;
  end

  // stage 2: accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

@@ design/iir_direct_form_one_filter.sv @@
`default_nettype none

// Direct-form-I IIR filter, order 1 to 3 (register REG_ORDER; 0 acts as 1),
// Q1.15 samples, Q3.15 coefficients, leading denominator fixed at one.
// A sample is accepted in the idle state. The single shared 16x18
// multiplier then runs 2*order + 1 products back to back, followed by the
// pipeline drain, round/saturate and output load states, after which the
// result is offered. in_ready is high only while the block is idle. It
// rises again in the cycle the result is loaded, so a new sample can be
// accepted only after the previous result is loaded. The result sits in
// an output register, so a stalled consumer holds the result without
// losing it. A result that is still held when the next one is ready keeps
// the block in its output state, and in_ready stays low until the held
// result is taken. Denominator terms are subtracted. The sum is rounded
// half up to Q1.15 and saturated, and that saturated value is also written
// into the output history. Configuration writes (cfg_ready is always high)
// must only be issued while idle.
module iir_direct_form_one_filter import iirdf1_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // sample input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sample_t              in_sample,
  // filtered output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sample_t                   out_filtered,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;

  // configuration registers
  logic [ORDER_W-1:0] order_r;
  coef_t              num_r [0:MAX_ORDER];
  coef_t              den_r [0:MAX_ORDER-1];

  // filter state
  sample_t            in_hist_r  [0:MAX_ORDER-1];
  sample_t            out_hist_r [0:MAX_ORDER-1];
  logic [ORDER_W-1:0] ring_pos_r;

  // per-transaction working registers
  logic [2:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [ORDER_W-1:0] pos_r;
  logic [ORDER_W-1:0] start_r;
  sample_t            x_r;
  sample_t            y_r;
  logic               out_valid_r;
  sample_t            out_data_r;

  logic [ORDER_W-1:0] ord;
  logic [ORDER_W-1:0] start;
  logic               last_step;
  logic               out_free;
  logic               in_acc;
  mac_ctl_t           mac_ctl;
  sample_t            mac_smp;
  coef_t              mac_coef;
  acc_t               acc;
  sample_t            y_new;

  function automatic logic [ORDER_W-1:0] ring_next(logic [ORDER_W-1:0] p,
                                                   logic [ORDER_W-1:0] o);
    logic [ORDER_W:0] n;
    n = {1'b0, p} + 3'd1;
    return (n >= {1'b0, o}) ? '0 : n[ORDER_W-1:0];
  endfunction

  // order 0 behaves as order 1; 2-bit field cannot exceed the maximum
  assign ord   = (order_r == '0) ? 2'd1 : order_r;
  // after an order change the ring position may be out of range
  assign start = (ring_pos_r < ord) ? ring_pos_r : '0;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == {ord, 1'b0});

  // Operand select. Even step k: num[k/2] * x_hist, odd step: den[k/2] *
  // y_hist (subtracted); the final step pairs num[order] with the new sample.
  always_comb begin
    mac_smp  = '0;
    mac_coef = '0;
    if (last_step) begin
      mac_smp = x_r;
    end else if (step_r[0]) begin
      case (pos_r)
        2'd0:    mac_smp = out_hist_r[0];
        2'd1:    mac_smp = out_hist_r[1];
        2'd2:    mac_smp = out_hist_r[2];
        default: mac_smp = '0;
      endcase
    end else begin
      case (pos_r)
        2'd0:    mac_smp = in_hist_r[0];
        2'd1:    mac_smp = in_hist_r[1];
        2'd2:    mac_smp = in_hist_r[2];
        default: mac_smp = '0;
      endcase
    end
    if (step_r[0]) begin
      case (step_r[2:1])
        2'd0:    mac_coef = den_r[0];
        2'd1:    mac_coef = den_r[1];
        2'd2:    mac_coef = den_r[2];
        default: mac_coef = '0;
      endcase
    end else begin
      mac_coef = num_r[step_r[2:1]];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mac_ctl   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mac_ctl.clr = 1'b1;
          state_nxt   = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.sub   = step_r[0] && !last_step;
        if (last_step) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  iirdf1_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .smp   (mac_smp),
    .coef  (mac_coef),
    .acc   (acc)
  );

  assign y_new = round_sat(acc);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= 2'd1;
      num_r[0] <= '0;
      num_r[1] <= 18'sd32768;
      num_r[2] <= '0;
      num_r[3] <= '0;
      den_r[0] <= '0;
      den_r[1] <= '0;
      den_r[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORDER: order_r  <= cfg_data[ORDER_W-1:0];
        REG_NUM_0: num_r[0] <= coef_t'(cfg_data);
        REG_NUM_1: num_r[1] <= coef_t'(cfg_data);
        REG_NUM_2: num_r[2] <= coef_t'(cfg_data);
        REG_NUM_3: num_r[3] <= coef_t'(cfg_data);
        REG_DEN_0: den_r[0] <= coef_t'(cfg_data);
        REG_DEN_1: den_r[1] <= coef_t'(cfg_data);
        REG_DEN_2: den_r[2] <= coef_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // control and history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      ring_pos_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        in_hist_r[i]  <= '0;
        out_hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        step_r  <= '0;
        pos_r   <= start;
        start_r <= start;
      end
      if (state_r == ST_MAC) begin
        step_r <= step_r + 3'd1;
        // ring index moves on after each input/output pair
        if (step_r[0]) begin
          pos_r <= ring_next(pos_r, ord);
        end
      end
      if (state_r == ST_ROUND) begin
        in_hist_r[start_r]  <= x_r;
        out_hist_r[start_r] <= y_new;
        ring_pos_r          <= ring_next(start_r, ord);
      end
      if (state_r == ST_SEND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_sample;
    end
    if (state_r == ST_ROUND) begin
      y_r <= y_new;
    end
    if (state_r == ST_SEND && out_free) begin
      out_data_r <= y_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

endmodule

`default_nettype wire

@@ sim/iir_direct_form_one_filter_test.sv @@
`default_nettype none

module iir_direct_form_one_filter_test;
  import iirdf1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest item plus a long sender gap and a long consumer stall
  // stays far below WATCHDOG_LIMIT, so reaching it means something is stuck.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int TAIL_CYCLES    = 24;
  localparam int RESET_CYCLES   = 12;

  localparam coef_t COEF_MAX = 18'sh1ffff;
  localparam coef_t COEF_MIN = 18'sh20000;

  // How coefficients are drawn for one random phase.
  typedef enum int {COEF_EXTREME, COEF_TAME, COEF_WILD} coef_mix_t;

  // One row of the directed plan: a register write, or a sample with an
  // optional hand-computed output.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    sample_t              x;
    logic                 known;
    sample_t              y;
  } plan_row_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  sample_t              in_sample    = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  sample_t              out_filtered;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_ORDER;
  logic [COEF_W-1:0]    cfg_data     = '0;

  // Predictor state: histories, ring pointer and a shadow of the registers.
  sample_t            x_hist [MAX_ORDER];
  sample_t            y_hist [MAX_ORDER];
  logic [1:0]         ring_pos;
  logic [ORDER_W-1:0] order_reg;
  coef_t              num_c  [MAX_ORDER+1];
  coef_t              den_c  [MAX_ORDER];

  sample_t pending_filtered [$];

  bit          no_idle;
  int          stall_left;
  int          idle_cycles;
  int          mismatches;
  int          samples_sent;
  int          results_seen;
  int          reg_writes;
  int          saturated;
  logic [3:0]  orders_seen;

  plan_row_t   plan [$];

  iir_direct_form_one_filter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_filter_state();
    for (int i = 0; i < MAX_ORDER; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
      den_c[i]  = '0;
    end
    for (int i = 0; i <= MAX_ORDER; i++) begin
      num_c[i] = '0;
    end
    num_c[1]  = 18'sd32768;
    order_reg = 2'd1;
    ring_pos  = '0;
  endfunction

  // Shadow register write; the order register keeps only its low bits.
  function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [COEF_W-1:0] data);
    case (idx)
      REG_ORDER: order_reg = data[ORDER_W-1:0];
      REG_NUM_0: num_c[0]  = coef_t'(data);
      REG_NUM_1: num_c[1]  = coef_t'(data);
      REG_NUM_2: num_c[2]  = coef_t'(data);
      REG_NUM_3: num_c[3]  = coef_t'(data);
      REG_DEN_0: den_c[0]  = coef_t'(data);
      REG_DEN_1: den_c[1]  = coef_t'(data);
      REG_DEN_2: den_c[2]  = coef_t'(data);
      default: ;
    endcase
  endfunction

  // One filter step: weighted history (oldest first), current sample times
  // the top numerator tap, round half up to Q1.15, saturate, update rings.
  function automatic sample_t filter_step(sample_t x);
    int unsigned ord;
    int unsigned start;
    int unsigned pos;
    int unsigned i;
    longint      acc;
    longint      q;
    sample_t     y;
    ord   = (order_reg == 0) ? 1 : int'(order_reg);
    // after an order change the pointer may sit past the new ring length
    start = (ring_pos < ord) ? ring_pos : 0;
    pos   = start;
    acc   = 0;
    for (i = 0; i < ord; i++) begin
      acc += longint'(x_hist[pos]) * longint'(num_c[i]);
      acc -= longint'(y_hist[pos]) * longint'(den_c[i]);
      pos  = (pos + 1 >= ord) ? 0 : pos + 1;
    end
    acc += longint'(x) * longint'(num_c[ord]);
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) begin
      y = 16'sh7fff;
      saturated++;
    end else if (q < -32768) begin
      y = 16'sh8000;
      saturated++;
    end else begin
      y = q[SAMPLE_W-1:0];
    end
    x_hist[start] = x;
    y_hist[start] = y;
    ring_pos      = (start + 1 >= ord) ? 2'd0 : 2'(start + 1);
    orders_seen[ord] = 1'b1;
    return y;
  endfunction

  // ---------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 16'sh7fff;
    if (r < 10) return 16'sh8000;
    if (r < 25) return sample_t'(int'($urandom_range(0, 128)) - 64);
    return sample_t'($urandom);
  endfunction

  function automatic coef_t pick_coef(coef_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      COEF_EXTREME: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      COEF_TAME: begin
        if (r < 15) return '0;
        return coef_t'(int'($urandom_range(0, 16384)) - 8192);
      end
      default: begin
        if (r < 10) return COEF_MAX;
        if (r < 20) return COEF_MIN;
        if (r < 30) return '0;
        if (r < 60) return coef_t'(int'($urandom_range(0, 65536)) - 32768);
        return coef_t'($urandom);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Leaves cfg_valid high so back-to-back writes need no second assignment
  // in one step; send_sample drops it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_reg_write(idx, data);
    reg_writes++;
  endtask

  // Hold off new samples until every pending output has been consumed;
  // the block is idle afterwards and may be reprogrammed.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
  endtask

  // Send one sample. The expected output is either given by hand or comes
  // from the predictor; the predictor runs in both cases to track state.
  task automatic send_sample(sample_t x, logic known, sample_t y_known);
    int      gap;
    sample_t y;
    cfg_valid <= 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!in_ready);
    y = filter_step(x);
    pending_filtered.push_back(known ? y_known : y);
    samples_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random back-pressure and the scoreboard check
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_filtered.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: filtered output %0d with no sample outstanding",
                   $realtime, out_filtered);
        end
      end else begin
        want = pending_filtered.pop_front();
        if (out_filtered !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: filtered mismatch, expected %0d got %0d",
                     $realtime, want, out_filtered);
          end
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d outputs pending",
               WATCHDOG_LIMIT, pending_filtered.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed plan helpers
  // ---------------------------------------------------------------------

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [COEF_W-1:0] data);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic plan_row_t sample_row(sample_t x);
    plan_row_t r;
    r   = '0;
    r.x = x;
    return r;
  endfunction

  function automatic plan_row_t known_row(sample_t x, sample_t y);
    plan_row_t r;
    r       = '0;
    r.x     = x;
    r.known = 1'b1;
    r.y     = y;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    coef_mix_t          mix;
    int                 phase_items;
    int                 random_sent;
    int                 phase;
    logic [COEF_W-1:0]  order_data;

    clear_filter_state();
    orders_seen = '0;

    plan = '{
      // reset state is a pass-through at order one
      known_row(16'sh7fff, 16'sh7fff),
      known_row(16'sh8000, 16'sh8000),
      known_row(16'sh0000, 16'sh0000),
      known_row(16'sh0001, 16'sh0001),
      known_row(-16'sh0001, -16'sh0001),
      // gain near +4: both rails saturate
      cfg_row(REG_NUM_1, COEF_MAX),
      known_row(16'sh7fff, 16'sh7fff),
      known_row(16'sh8000, 16'sh8000),
      // gain -4 on the most negative sample overflows positive
      cfg_row(REG_NUM_1, COEF_MIN),
      known_row(16'sh8000, 16'sh7fff),
      // gain one half: ties round up
      cfg_row(REG_NUM_1, 18'sd16384),
      known_row(16'sh0001, 16'sh0001),
      known_row(-16'sh0001, 16'sh0000),
      // order zero acts as order one; junk above bit 1 is dropped
      cfg_row(REG_ORDER, 18'h3fffc),
      cfg_row(REG_NUM_1, 18'sd32768),
      known_row(16'sd12345, 16'sd12345),
      // full third order with mixed taps
      cfg_row(REG_ORDER, 18'd3),
      cfg_row(REG_NUM_0, 18'sd16384),
      cfg_row(REG_NUM_1, -18'sd8192),
      cfg_row(REG_NUM_2, 18'sd8192),
      cfg_row(REG_NUM_3, 18'sd32768),
      cfg_row(REG_DEN_0, -18'sd4096),
      cfg_row(REG_DEN_1, 18'sd4096),
      cfg_row(REG_DEN_2, -18'sd16384),
      sample_row(16'sd20000),
      sample_row(-16'sd20000),
      sample_row(16'sh7fff),
      sample_row(16'sh8000),
      sample_row(16'sd1000),
      // ring pointer is now 2: dropping to order two wraps it to zero
      cfg_row(REG_ORDER, 18'd2),
      sample_row(16'sd7000),
      sample_row(-16'sd7000),
      // back to order one with extreme feedback
      cfg_row(REG_ORDER, 18'd1),
      cfg_row(REG_DEN_0, COEF_MAX),
      cfg_row(REG_NUM_0, COEF_MIN),
      sample_row(16'sd30000),
      sample_row(-16'sd30000)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (in_valid) drain();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_sample(plan[k].x, plan[k].known, plan[k].y);
      end
    end

    // Random phases: each drains the filter, reprograms it (order always,
    // coefficients mostly) and streams a burst of samples. Histories carry
    // over between phases, so order changes with live state are common.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      if (phase == 0) begin
        mix = COEF_EXTREME;
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:11]:  mix = COEF_TAME;
          [12:16]: mix = COEF_WILD;
          default: mix = COEF_EXTREME;
        endcase
      end
      no_idle    = ($urandom_range(0, 5) == 0);
      order_data = COEF_W'($urandom);
      order_data[ORDER_W-1:0] = (phase == 0) ? ORDER_W'(MAX_ORDER)
                                             : ORDER_W'($urandom_range(0, 3));
      write_reg(REG_ORDER, order_data);
      for (int r = int'(REG_NUM_0); r <= int'(REG_DEN_2); r++) begin
        if (phase == 0 || $urandom_range(0, 9) < 7) begin
          write_reg(CFG_IDX_W'(r), pick_coef(mix));
        end
      end
      phase_items = $urandom_range(40, 200);
      for (int n = 0; n < phase_items && random_sent < RANDOM_ITEMS; n++) begin
        send_sample(pick_sample(), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d samples through %0d register setups, %0d register writes",
             samples_sent, phase, reg_writes);
    $display("%0d outputs checked, %0d saturated, effective orders seen 3..1: %b",
             results_seen, saturated, orders_seen[3:1]);
    if (mismatches == 0 && pending_filtered.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d outputs never arrived",
               mismatches, pending_filtered.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
